// File: rtl/lcs_pkg.sv
// Package for the LED color store: payload structs, command opcodes and
// color constants. No dependencies; used by every module of the block.
`default_nettype none

package lcs_pkg;

  // Default number of LEDs in the store.
  localparam int NumLedsDefault = 48;

  // Command opcodes.
  localparam logic [7:0] OpSetAll = 8'd1;
  localparam logic [7:0] OpSetOne = 8'd2;
  localparam logic [7:0] OpClear  = 8'd3;
  localparam logic [7:0] OpFocus  = 8'd4;

  // Item kinds.
  localparam logic KindCommand = 1'b0;
  localparam logic KindRead    = 1'b1;

  // Minimum packet lengths per command.
  localparam logic [5:0] MinLenSetAll = 6'd4;
  localparam logic [5:0] MinLenSetOne = 6'd5;
  localparam logic [5:0] MinLenFocus  = 6'd2;

  localparam logic [7:0] NoFocus = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  localparam color_t ColorBlack = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
  localparam color_t ColorWhite = '{red: 8'd255, green: 8'd255, blue: 8'd255};
  localparam color_t ColorDim   = '{red: 8'd0,   green: 8'd0,   blue: 8'd30};
  localparam color_t ColorLayer0 = '{red: 8'd0,  green: 8'd0,   blue: 8'd100};
  localparam color_t ColorLayer1 = '{red: 8'd0,  green: 8'd100, blue: 8'd0};

  typedef struct packed {
    logic       item_kind;
    logic [7:0] opcode;
    logic [5:0] packet_length;
    logic [7:0] led_addr;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       active_layer;
  } in_t;

  typedef struct packed {
    logic [7:0] echoed_command;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       override_active;
    logic [7:0] focused_index;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/lcs_store.sv
// Color memory of the LED store: one write port, one registered read port,
// and per-entry valid bits so that never-written entries read as black.
// Depends on lcs_pkg.
`default_nettype none

module lcs_store #(
  parameter int NumLeds = lcs_pkg::NumLedsDefault,
  localparam int AddrW = (NumLeds > 1) ? $clog2(NumLeds) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire lcs_pkg::color_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output lcs_pkg::color_t      rdata_o
);

  lcs_pkg::color_t mem [NumLeds];
  logic [NumLeds-1:0] valid_q;
  lcs_pkg::color_t rdata_q;
  logic rvalid_q;

  // Memory write and registered read; contents need no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Valid bits stand in for the all-zero reset contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : lcs_pkg::ColorBlack;

endmodule

`default_nettype wire

// File: rtl/led_color_store_with_focus.sv
// Top level of the LED color store with host override and focus.
// Depends on lcs_pkg and lcs_store.
`default_nettype none

// Each transfer on the input produces exactly one result transfer. Commands
// that touch at most one LED (set one, clear, a short packet, an unknown
// opcode, focus on an index out of range) present their result in the cycle
// after the input transfer. A read passes through the registered read port of
// the color memory and then the result register. Set all and an in-range
// focus walk the single memory write port over every entry, so the next
// input transfer is taken only after the sweep has ended. Input is also held
// off while a result still waits for its output transfer.
module led_color_store_with_focus #(
  parameter int NUM_LEDS = lcs_pkg::NumLedsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire lcs_pkg::in_t in_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output lcs_pkg::out_t     out_o
);

  localparam int IdxW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_LEDS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StRead
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] tgt_q, tgt_d;
  logic ovr_q, ovr_d;
  logic [7:0] focus_q, focus_d;
  lcs_pkg::color_t fill_q, fill_d;
  logic sweep_focus_q, sweep_focus_d;
  logic layer_q, layer_d;
  logic rd_hit_q, rd_hit_d;
  logic out_valid_q, out_valid_d;
  lcs_pkg::out_t out_q, out_d;

  logic in_xfer;
  logic in_range;
  logic [IdxW-1:0] in_idx;
  logic we;
  logic [IdxW-1:0] waddr;
  lcs_pkg::color_t wdata;
  logic re;
  lcs_pkg::color_t rdata;
  lcs_pkg::color_t rd_color;

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_range    = in_i.led_addr < 8'(NUM_LEDS);
  assign in_idx      = in_i.led_addr[IdxW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Memory port control: set one writes at the transfer, sweeps write one
  // entry per cycle, reads issue at the transfer.
  always_comb begin
    we    = 1'b0;
    waddr = in_idx;
    wdata = '{red: in_i.red_in, green: in_i.green_in, blue: in_i.blue_in};
    if (state_q == StSweep) begin
      we    = 1'b1;
      waddr = cnt_q;
      if (sweep_focus_q) begin
        wdata = (cnt_q == tgt_q) ? lcs_pkg::ColorWhite : lcs_pkg::ColorDim;
      end else begin
        wdata = fill_q;
      end
    end else if (in_xfer && in_i.item_kind == lcs_pkg::KindCommand &&
                 in_i.opcode == lcs_pkg::OpSetOne &&
                 in_i.packet_length >= lcs_pkg::MinLenSetOne && in_range) begin
      we = 1'b1;
    end
  end

  // Reads past the end of the store never reach the memory.
  assign re = in_xfer && (in_i.item_kind == lcs_pkg::KindRead) && in_range;

  lcs_store #(
    .NumLeds(NUM_LEDS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (in_idx),
    .rdata_o (rdata)
  );

  // Color shown by the LED being read.
  always_comb begin
    if (!rd_hit_q) begin
      rd_color = lcs_pkg::ColorBlack;
    end else if (ovr_q) begin
      rd_color = rdata;
    end else if (layer_q) begin
      rd_color = lcs_pkg::ColorLayer1;
    end else begin
      rd_color = lcs_pkg::ColorLayer0;
    end
  end

  // Next-state logic for the sequencer, flags and the result register.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    tgt_d         = tgt_q;
    ovr_d         = ovr_q;
    focus_d       = focus_q;
    fill_d        = fill_q;
    sweep_focus_d = sweep_focus_q;
    layer_d       = layer_q;
    rd_hit_d      = rd_hit_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_i.item_kind == lcs_pkg::KindRead) begin
            layer_d  = in_i.active_layer;
            rd_hit_d = in_range;
            state_d  = StRead;
          end else begin
            case (in_i.opcode)
              lcs_pkg::OpSetAll: begin
                if (in_i.packet_length >= lcs_pkg::MinLenSetAll) begin
                  ovr_d         = 1'b1;
                  focus_d       = lcs_pkg::NoFocus;
                  fill_d        = '{red: in_i.red_in, green: in_i.green_in,
                                    blue: in_i.blue_in};
                  sweep_focus_d = 1'b0;
                  cnt_d         = '0;
                  state_d       = StSweep;
                end
              end
              lcs_pkg::OpSetOne: begin
                if (in_i.packet_length >= lcs_pkg::MinLenSetOne) begin
                  ovr_d = 1'b1;
                end
              end
              lcs_pkg::OpClear: begin
                ovr_d   = 1'b0;
                focus_d = lcs_pkg::NoFocus;
              end
              lcs_pkg::OpFocus: begin
                if (in_i.packet_length >= lcs_pkg::MinLenFocus) begin
                  ovr_d = 1'b1;
                  if (in_range) begin
                    focus_d       = in_i.led_addr;
                    tgt_d         = in_idx;
                    sweep_focus_d = 1'b1;
                    cnt_d         = '0;
                    state_d       = StSweep;
                  end
                end
              end
              default: begin
              end
            endcase
            out_valid_d = 1'b1;
            out_d = '{echoed_command: in_i.opcode, red_out: 8'd0,
                      green_out: 8'd0, blue_out: 8'd0,
                      override_active: ovr_d, focused_index: focus_d};
          end
        end
      end
      StSweep: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      StRead: begin
        out_valid_d = 1'b1;
        out_d = '{echoed_command: 8'd0, red_out: rd_color.red,
                  green_out: rd_color.green, blue_out: rd_color.blue,
                  override_active: ovr_q, focused_index: focus_q};
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State, flags and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cnt_q         <= '0;
      ovr_q         <= 1'b0;
      focus_q       <= lcs_pkg::NoFocus;
      sweep_focus_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      ovr_q         <= ovr_d;
      focus_q       <= focus_d;
      sweep_focus_q <= sweep_focus_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    tgt_q    <= tgt_d;
    fill_q   <= fill_d;
    layer_q  <= layer_d;
    rd_hit_q <= rd_hit_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

// File: test/tb_led_color_store_with_focus.sv
// Self-checking testbench for led_color_store_with_focus: directed and random
// command and read items, with a scoreboard that predicts every result.
// Depends on lcs_pkg and the RTL of the block.

module tb_led_color_store_with_focus;

  localparam int ClkPeriod      = 4;
  localparam int ResetCycles    = 12;
  localparam int RandomItems    = 1050;
  localparam int LongHoldCycles = 400;
  localparam int NumLeds        = lcs_pkg::NumLedsDefault;
  localparam int SettleCycles   = 2 * NumLeds + 10;
  localparam int TimeoutCycles  = 1000000;

  // Scoreboard: tracks the LED store, override flag and focus, queues the
  // predicted result of every accepted input and checks the results in order.
  class color_scoreboard;
    lcs_pkg::color_t led_colors [NumLeds];
    logic            override_on;
    logic [7:0]      focus_led;
    lcs_pkg::out_t   expected_results [$];
    int              mismatch_count;
    int              results_checked;

    function new();
      foreach (led_colors[i]) led_colors[i] = lcs_pkg::ColorBlack;
      override_on     = 1'b0;
      focus_led       = lcs_pkg::NoFocus;
      mismatch_count  = 0;
      results_checked = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Update the state for one accepted input and queue its result.
    function void note_input(lcs_pkg::in_t item);
      lcs_pkg::out_t   res;
      lcs_pkg::color_t shade;
      lcs_pkg::color_t paint;
      res   = '0;
      shade = lcs_pkg::ColorBlack;
      paint = {item.red_in, item.green_in, item.blue_in};
      if (item.item_kind == lcs_pkg::KindCommand) begin
        res.echoed_command = item.opcode;
        case (item.opcode)
          lcs_pkg::OpSetAll: begin
            if (item.packet_length >= lcs_pkg::MinLenSetAll) begin
              override_on = 1'b1;
              focus_led   = lcs_pkg::NoFocus;
              foreach (led_colors[i]) led_colors[i] = paint;
            end
          end
          lcs_pkg::OpSetOne: begin
            if (item.packet_length >= lcs_pkg::MinLenSetOne) begin
              override_on = 1'b1;
              if (item.led_addr < NumLeds) begin
                led_colors[item.led_addr] = paint;
              end
            end
          end
          lcs_pkg::OpClear: begin
            override_on = 1'b0;
            focus_led   = lcs_pkg::NoFocus;
          end
          lcs_pkg::OpFocus: begin
            if (item.packet_length >= lcs_pkg::MinLenFocus) begin
              override_on = 1'b1;
              if (item.led_addr < NumLeds) begin
                focus_led = item.led_addr;
                foreach (led_colors[i]) led_colors[i] = lcs_pkg::ColorDim;
                led_colors[item.led_addr] = lcs_pkg::ColorWhite;
              end
            end
          end
          default: ;
        endcase
      end else begin
        // A read in range shows the host color under override, else the layer color.
        if (item.led_addr < NumLeds) begin
          if (override_on) begin
            shade = led_colors[item.led_addr];
          end else if (item.active_layer) begin
            shade = lcs_pkg::ColorLayer1;
          end else begin
            shade = lcs_pkg::ColorLayer0;
          end
        end
        res.red_out   = shade.red;
        res.green_out = shade.green;
        res.blue_out  = shade.blue;
      end
      res.override_active = override_on;
      res.focused_index   = focus_led;
      expected_results.push_back(res);
    endfunction

    task report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Compare one result transfer with the oldest prediction.
    task check_result(input lcs_pkg::out_t got);
      lcs_pkg::out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none pending", results_checked));
      end else begin
        want = expected_results.pop_front();
        if (got.echoed_command !== want.echoed_command)
          report_mismatch($sformatf("result %0d echoed_command got %0d want %0d",
                                    results_checked, got.echoed_command, want.echoed_command));
        if (got.red_out !== want.red_out)
          report_mismatch($sformatf("result %0d red_out got %0d want %0d",
                                    results_checked, got.red_out, want.red_out));
        if (got.green_out !== want.green_out)
          report_mismatch($sformatf("result %0d green_out got %0d want %0d",
                                    results_checked, got.green_out, want.green_out));
        if (got.blue_out !== want.blue_out)
          report_mismatch($sformatf("result %0d blue_out got %0d want %0d",
                                    results_checked, got.blue_out, want.blue_out));
        if (got.override_active !== want.override_active)
          report_mismatch($sformatf("result %0d override_active got %0b want %0b",
                                    results_checked, got.override_active,
                                    want.override_active));
        if (got.focused_index !== want.focused_index)
          report_mismatch($sformatf("result %0d focused_index got %0d want %0d",
                                    results_checked, got.focused_index, want.focused_index));
      end
      results_checked++;
    endtask
  endclass

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  lcs_pkg::in_t  in_i        = '0;
  lcs_pkg::out_t out_o;

  bit hold_off_req = 1'b0;

  color_scoreboard sb = new();

  led_color_store_with_focus u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Build a command item; fields a command does not use stay zero.
  function automatic lcs_pkg::in_t cmd_item(logic [7:0] op, logic [5:0] len,
                                            logic [7:0] idx, logic [7:0] r,
                                            logic [7:0] g, logic [7:0] b);
    lcs_pkg::in_t item;
    item               = '0;
    item.item_kind     = lcs_pkg::KindCommand;
    item.opcode        = op;
    item.packet_length = len;
    item.led_addr      = idx;
    item.red_in        = r;
    item.green_in      = g;
    item.blue_in       = b;
    return item;
  endfunction

  function automatic lcs_pkg::in_t read_item(logic [7:0] idx, logic layer);
    lcs_pkg::in_t item;
    item              = '0;
    item.item_kind    = lcs_pkg::KindRead;
    item.led_addr     = idx;
    item.active_layer = layer;
    return item;
  endfunction

  // Random item: mostly reads and well-formed commands, some short packets,
  // out-of-range indexes and unknown opcodes. Unused fields are random too.
  function automatic lcs_pkg::in_t random_item();
    lcs_pkg::in_t item;
    int           pick;
    item               = '0;
    item.opcode        = 8'($urandom_range(0, 255));
    item.packet_length = 6'($urandom_range(0, 32));
    item.red_in        = 8'($urandom_range(0, 255));
    item.green_in      = 8'($urandom_range(0, 255));
    item.blue_in       = 8'($urandom_range(0, 255));
    item.active_layer  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) begin
      item.led_addr = 8'($urandom_range(0, NumLeds - 1));
    end else begin
      item.led_addr = 8'($urandom_range(NumLeds, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      item.item_kind = lcs_pkg::KindRead;
    end else begin
      item.item_kind = lcs_pkg::KindCommand;
      if (pick < 70) begin
        item.opcode = lcs_pkg::OpSetOne;
        if ($urandom_range(0, 9) != 0)
          item.packet_length = 6'($urandom_range(lcs_pkg::MinLenSetOne, 32));
      end else if (pick < 77) begin
        item.opcode = lcs_pkg::OpSetAll;
        if ($urandom_range(0, 9) != 0)
          item.packet_length = 6'($urandom_range(lcs_pkg::MinLenSetAll, 32));
      end else if (pick < 84) begin
        item.opcode = lcs_pkg::OpFocus;
        if ($urandom_range(0, 9) != 0)
          item.packet_length = 6'($urandom_range(lcs_pkg::MinLenFocus, 32));
      end else if (pick < 89) begin
        item.opcode = lcs_pkg::OpClear;
      end
    end
    return item;
  endfunction

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(input lcs_pkg::in_t item);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(item);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic wait_drained();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result checker: a transfer happens where valid and ready are both high.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_o);
    end
  end

  // Receiver ready: phases of different stall density, plus long hold-offs
  // on request from the stimulus.
  initial begin : receiver_ready
    int mode_left;
    int ready_pct;
    int hold_left;
    mode_left = 0;
    ready_pct = 100;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LongHoldCycles;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 150);
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 75;
          2:       ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Stimulus: reset, directed items, then random bursts.
  initial begin : stimulus
    int sent;
    int burst_len;
    int next_drain;
    int next_hold;
    sent       = 0;
    next_drain = 250;
    next_hold  = 300;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reads at reset: layer colors and black past the end of the store.
    send_item(read_item(8'd0, 1'b0));
    send_item(read_item(8'd47, 1'b1));
    send_item(read_item(8'd48, 1'b0));
    send_item(read_item(8'd255, 1'b1));
    // Unknown opcodes are echoed and change nothing.
    send_item(cmd_item(8'd0, 6'd32, 8'd0, 8'd255, 8'd255, 8'd255));
    send_item(cmd_item(8'd255, 6'd63, 8'd255, 8'd0, 8'd0, 8'd0));
    // Set all: short packet, then the minimum length.
    send_item(cmd_item(lcs_pkg::OpSetAll, 6'd3, 8'd0, 8'd255, 8'd255, 8'd255));
    send_item(cmd_item(lcs_pkg::OpSetAll, 6'd4, 8'd255, 8'd255, 8'd0, 8'd170));
    send_item(read_item(8'd0, 1'b0));
    // Set one: short packet, both ends of the store, indexes out of range.
    send_item(cmd_item(lcs_pkg::OpSetOne, 6'd4, 8'd5, 8'd9, 8'd9, 8'd9));
    send_item(cmd_item(lcs_pkg::OpSetOne, 6'd5, 8'd0, 8'd1, 8'd2, 8'd3));
    send_item(cmd_item(lcs_pkg::OpSetOne, 6'd32, 8'd47, 8'd85, 8'd255, 8'd0));
    send_item(cmd_item(lcs_pkg::OpSetOne, 6'd5, 8'd48, 8'd9, 8'd9, 8'd9));
    send_item(cmd_item(lcs_pkg::OpSetOne, 6'd5, 8'd255, 8'd9, 8'd9, 8'd9));
    send_item(read_item(8'd0, 1'b1));
    send_item(read_item(8'd47, 1'b0));
    // Focus: short packet, out of range, then both ends of the store.
    send_item(cmd_item(lcs_pkg::OpFocus, 6'd1, 8'd3, 8'd0, 8'd0, 8'd0));
    send_item(cmd_item(lcs_pkg::OpFocus, 6'd2, 8'd48, 8'd0, 8'd0, 8'd0));
    send_item(cmd_item(lcs_pkg::OpFocus, 6'd2, 8'd47, 8'd0, 8'd0, 8'd0));
    send_item(read_item(8'd47, 1'b0));
    send_item(read_item(8'd46, 1'b1));
    send_item(cmd_item(lcs_pkg::OpFocus, 6'd32, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(read_item(8'd0, 1'b0));
    // Clear drops override and focus; reads fall back to the layer colors.
    send_item(cmd_item(lcs_pkg::OpClear, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(read_item(8'd0, 1'b0));
    send_item(read_item(8'd200, 1'b1));
    wait_drained();

    // Random bursts with random gaps; now and then a long receiver hold-off
    // while items keep coming, and a pause until every result is back.
    while (sent < RandomItems) begin
      if (sent >= next_hold) begin
        next_hold    = next_hold + 400;
        hold_off_req = 1'b1;
        burst_len    = 30;
      end else begin
        burst_len = $urandom_range(1, 24);
      end
      repeat (burst_len) begin
        send_item(random_item());
        sent++;
      end
      if (sent >= next_drain) begin
        next_drain = next_drain + 250;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 10));
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("Mismatches found");
    $finish;
  end

endmodule
